FILE: hw/rtl/sacc_pkg.sv
// ----------------------------------------------------------------------------
// sacc_pkg
// shared geometry, codes, payload types and control structs of the
// set-associative write-through cache controller
// ----------------------------------------------------------------------------
package sacc_pkg;

    // fixed geometry: both are powers of two so the address splits into fields
    localparam int SETS            = 16;
    localparam int WORDS_PER_LINE  = 8;

    // defaults for the top-level parameters
    localparam int WAYS_DEF        = 3;
    localparam int COUNT_WIDTH_DEF = 16;

    // address fields
    localparam int OFF_W = $clog2(WORDS_PER_LINE);
    localparam int SET_W = $clog2(SETS);
    localparam int TAG_W = 32 - 2 - OFF_W - SET_W;

    // request op codes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_FILL  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_FETCH = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_BUSY  = 2'd3;

    // input request
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] addr;
        logic [31:0] data;
    } t_in_item;

    // result
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] out_addr;
        logic [31:0] out_data;
        logic        was_hit;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic fill_wr;
        logic fill_done;
        logic hit_upd;
        logic miss_start;
        logic busy;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic       out_valid;
        logic [1:0] op;
        logic       pend_valid;
        logic       fill_last;
        logic       hit;
    } t_sts;

endpackage

FILE: hw/rtl/sacc_ram.sv
// ----------------------------------------------------------------------------
// sacc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module sacc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/sacc_ctrl.sv
// ----------------------------------------------------------------------------
// sacc_ctrl
// controller: takes one request, then sequences its execution and decides
// which datapath action it needs
// ----------------------------------------------------------------------------
module sacc_ctrl import sacc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   w_go;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // requests are taken only when idle
    assign o_in_stall = (r_state != S_IDLE);

    // execution proceeds once the result register can take a new result
    assign w_go = (r_state == S_EXEC) && (!i_sts.out_valid || !i_out_stall);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_go) begin
                    n_state = S_IDLE;
                    case (i_sts.op)
                        OP_READ, OP_WRITE: begin
                            if (i_sts.pend_valid) begin
                                o_cmd.busy = 1'b1;
                            end else if (i_sts.hit) begin
                                o_cmd.hit_upd = 1'b1;
                            end else begin
                                o_cmd.miss_start = 1'b1;
                            end
                        end
                        OP_FILL: begin
                            if (i_sts.pend_valid) begin
                                o_cmd.fill_wr   = 1'b1;
                                o_cmd.fill_done = i_sts.fill_last;
                            end
                        end
                        default: begin
                            // unused op code: dropped
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/sacc_dp.sv
// ----------------------------------------------------------------------------
// sacc_dp
// datapath: per-way tag/count and line rams, valid bits, miss tracking,
// victim choice and the result register
// ----------------------------------------------------------------------------
module sacc_dp import sacc_pkg::*; #(
    parameter int WAYS        = WAYS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_item,
    input  logic      i_out_stall,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENT_W      = TAG_W + COUNT_WIDTH;
    localparam int DATA_DEPTH = SETS * WORDS_PER_LINE;
    localparam int DADDR_W    = SET_W + OFF_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // latched request
    t_in_item r_item;

    // valid bits, one per line
    logic [SETS-1:0] r_valid [WAYS];

    // outstanding miss
    logic             r_pend_valid;
    logic [1:0]       r_pend_op;
    logic [31:0]      r_pend_addr;
    logic [31:0]      r_pend_data;
    logic [WAY_W-1:0] r_victim;
    logic [OFF_W-1:0] r_fill_cnt;
    logic [31:0]      r_fill_word;

    // result register
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item n_out_item;
    logic      w_load;

    // address fields of the latched request and of the pending miss
    logic [SET_W-1:0] w_set, w_in_set, w_p_set;
    logic [OFF_W-1:0] w_off, w_in_off, w_p_off;
    logic [TAG_W-1:0] w_tag, w_p_tag;

    // ram ports
    logic [ENT_W-1:0]   w_ent   [WAYS];
    logic [31:0]        w_rdata [WAYS];
    logic [WAYS-1:0]    w_tag_we;
    logic [SET_W-1:0]   w_tag_waddr;
    logic [ENT_W-1:0]   w_tag_wdata;
    logic [WAYS-1:0]    w_dat_we;
    logic [DADDR_W-1:0] w_dat_waddr;
    logic [31:0]        w_dat_wdata;

    // lookup
    logic [WAYS-1:0]        w_hit_vec;
    logic [WAY_W-1:0]       w_hit_way;
    logic [COUNT_WIDTH-1:0] w_cnt [WAYS];
    logic [COUNT_WIDTH-1:0] w_hit_cnt;
    logic [COUNT_WIDTH-1:0] w_bump;
    logic [WAY_W-1:0]       w_victim;
    logic [COUNT_WIDTH-1:0] w_best_cnt;
    logic                   w_fill_hits_off;

    assign w_set    = r_item.addr[2+OFF_W +: SET_W];
    assign w_off    = r_item.addr[2 +: OFF_W];
    assign w_tag    = r_item.addr[31 -: TAG_W];
    assign w_in_set = i_in_item.addr[2+OFF_W +: SET_W];
    assign w_in_off = i_in_item.addr[2 +: OFF_W];
    assign w_p_set  = r_pend_addr[2+OFF_W +: SET_W];
    assign w_p_off  = r_pend_addr[2 +: OFF_W];
    assign w_p_tag  = r_pend_addr[31 -: TAG_W];

    // per-way storage, read when a request is taken
    for (genvar g = 0; g < WAYS; g++) begin : gen_way
        sacc_ram #(
            .WIDTH (ENT_W),
            .DEPTH (SETS)
        ) u_tag_ram (
            .i_clk   (i_clk),
            .i_we    (w_tag_we[g]),
            .i_waddr (w_tag_waddr),
            .i_wdata (w_tag_wdata),
            .i_re    (i_cmd.latch),
            .i_raddr (w_in_set),
            .o_rdata (w_ent[g])
        );

        sacc_ram #(
            .WIDTH (32),
            .DEPTH (DATA_DEPTH)
        ) u_line_ram (
            .i_clk   (i_clk),
            .i_we    (w_dat_we[g]),
            .i_waddr (w_dat_waddr),
            .i_wdata (w_dat_wdata),
            .i_re    (i_cmd.latch),
            .i_raddr ({w_in_set, w_in_off}),
            .o_rdata (w_rdata[g])
        );
    end

    // tag compare and use counts; an invalid line counts as zero
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            w_hit_vec[w] = r_valid[w][w_set] && (w_ent[w][ENT_W-1 -: TAG_W] == w_tag);
            w_cnt[w]     = r_valid[w][w_set] ? w_ent[w][COUNT_WIDTH-1:0] : '0;
        end
    end

    // lowest hitting way
    always_comb begin
        w_hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (w_hit_vec[w]) begin
                w_hit_way = WAY_W'(w);
            end
        end
    end

    // saturating count bump
    assign w_hit_cnt = w_cnt[w_hit_way];
    assign w_bump    = (w_hit_cnt == COUNT_MAX) ? w_hit_cnt : w_hit_cnt + COUNT_WIDTH'(1);

    // least used way, lowest way on a tie
    always_comb begin
        w_victim   = '0;
        w_best_cnt = w_cnt[0];
        for (int w = 1; w < WAYS; w++) begin
            if (w_cnt[w] < w_best_cnt) begin
                w_victim   = WAY_W'(w);
                w_best_cnt = w_cnt[w];
            end
        end
    end

    assign w_fill_hits_off = (r_fill_cnt == w_p_off);

    // ram writes
    always_comb begin
        w_tag_we    = '0;
        w_tag_waddr = w_set;
        w_tag_wdata = {w_tag, w_bump};
        w_dat_we    = '0;
        w_dat_waddr = {w_set, w_off};
        w_dat_wdata = r_item.data;
        if (i_cmd.hit_upd) begin
            w_tag_we[w_hit_way] = 1'b1;
            if (r_item.op == OP_WRITE) begin
                w_dat_we[w_hit_way] = 1'b1;
            end
        end
        if (i_cmd.fill_wr) begin
            // a pending write lands directly in place of its fill word
            w_dat_we[r_victim] = 1'b1;
            w_dat_waddr        = {w_p_set, r_fill_cnt};
            if ((r_pend_op == OP_WRITE) && w_fill_hits_off) begin
                w_dat_wdata = r_pend_data;
            end
            if (i_cmd.fill_done) begin
                w_tag_we[r_victim] = 1'b1;
                w_tag_waddr        = w_p_set;
                w_tag_wdata        = {w_p_tag, COUNT_WIDTH'(1)};
            end
        end
    end

    // request latch and fill word capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_in_item;
        end
        if (i_cmd.miss_start) begin
            r_pend_op   <= r_item.op;
            r_pend_addr <= r_item.addr;
            r_pend_data <= r_item.data;
        end
        if (i_cmd.fill_wr && w_fill_hits_off) begin
            r_fill_word <= r_item.data;
        end
    end

    // miss tracking and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_victim     <= '0;
            r_fill_cnt   <= '0;
            for (int w = 0; w < WAYS; w++) begin
                r_valid[w] <= '0;
            end
        end else begin
            if (i_cmd.miss_start) begin
                r_pend_valid <= 1'b1;
                r_victim     <= w_victim;
                r_fill_cnt   <= '0;
            end
            if (i_cmd.fill_wr) begin
                r_fill_cnt <= r_fill_cnt + OFF_W'(1);
                if (i_cmd.fill_done) begin
                    r_pend_valid               <= 1'b0;
                    r_fill_cnt                 <= '0;
                    r_valid[r_victim][w_p_set] <= 1'b1;
                end
            end
        end
    end

    // result selection
    assign w_load = i_cmd.busy | i_cmd.hit_upd | i_cmd.miss_start | i_cmd.fill_done;

    always_comb begin
        n_out_item = '0;
        if (i_cmd.busy) begin
            n_out_item.kind = KIND_BUSY;
        end else if (i_cmd.miss_start) begin
            n_out_item.kind     = KIND_FETCH;
            n_out_item.out_addr = {r_item.addr[31:2+OFF_W], {(2 + OFF_W){1'b0}}};
        end else if (i_cmd.hit_upd) begin
            n_out_item.was_hit = 1'b1;
            if (r_item.op == OP_WRITE) begin
                n_out_item.kind     = KIND_WRITE;
                n_out_item.out_addr = {r_item.addr[31:2], 2'b00};
                n_out_item.out_data = r_item.data;
            end else begin
                n_out_item.kind     = KIND_READ;
                n_out_item.out_data = w_rdata[w_hit_way];
            end
        end else if (i_cmd.fill_done) begin
            if (r_pend_op == OP_WRITE) begin
                n_out_item.kind     = KIND_WRITE;
                n_out_item.out_addr = {r_pend_addr[31:2], 2'b00};
                n_out_item.out_data = r_pend_data;
            end else begin
                n_out_item.kind     = KIND_READ;
                n_out_item.out_data = w_fill_hits_off ? r_item.data : r_fill_word;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // status
    assign o_sts.out_valid  = r_out_valid;
    assign o_sts.op         = r_item.op;
    assign o_sts.pend_valid = r_pend_valid;
    assign o_sts.fill_last  = (r_fill_cnt == OFF_W'(WORDS_PER_LINE - 1));
    assign o_sts.hit        = |w_hit_vec;

    // checks
    a_fill_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill_done |=> !r_pend_valid)
        else $error("miss still pending after the last fill word");

    a_busy_needs_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.busy |-> r_pend_valid)
        else $error("busy reject without a pending miss");

    a_miss_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.miss_start |=> (r_pend_valid && (r_fill_cnt == '0)))
        else $error("miss did not arm the fill sequence");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.hit_upd |-> $onehot(w_hit_vec))
        else $error("hit update without exactly one hitting way");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !w_load)
        else $error("held result overwritten");

endmodule

FILE: hw/rtl/set_assoc_cache_controller_top.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_controller_top
// set-associative, write-allocate, write-through cache controller with
// least-frequently-used replacement
// ----------------------------------------------------------------------------
// A request is first taken, which starts a registered read of every
// way's tag/count ram and line ram, and then handled in an execution
// state that compares tags, updates the rams and loads the result
// register. Input stall is high during the execution state, and
// execution waits while an earlier result is still held by output stall.
// A read or write miss returns a line fetch request; the controller then
// expects one fill request per word of the line, in offset order, and the
// last of them completes the access. Reads and writes that arrive while a
// miss is outstanding are answered with a busy reject. Valid bits live in
// flip-flops, so the block is ready directly after reset with no clearing
// pass.
// ----------------------------------------------------------------------------
module set_assoc_cache_controller_top import sacc_pkg::*; #(
    parameter int WAYS        = WAYS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_cmd w_cmd;
    t_sts w_sts;

    // request sequencing
    sacc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // storage, lookup and results
    sacc_dp #(
        .WAYS        (WAYS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
